/* src/crcpd_pkg.sv */
// Shared constants, types and the CRC byte update for the PWM command deframer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package crcpd_pkg;

  // Frame geometry
  localparam int unsigned FRAME_LEN_DEF  = 11;
  localparam int unsigned PAYLOAD_BYTES  = 8;
  localparam int unsigned DUTY_COUNT     = 4;
  localparam logic [7:0]  START_BYTE     = 8'hFF;

  // CRC-16/MODBUS
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // Servo scaling: floor(period_top * (OFFSET + v) / 20460), 20460 = 4 * 5115
  localparam logic [16:0] SERVO_OFFSET   = 17'd1023;
  localparam int unsigned SERVO_PRE_SHIFT = 2;
  localparam logic [12:0] SERVO_ODD_DIV  = 13'd5115;
  localparam int unsigned RECIP_SHIFT    = 31;
  localparam int unsigned QUOT_W         = 19;
  localparam logic [QUOT_W-1:0] SERVO_RECIP =
    QUOT_W'((64'd1 << RECIP_SHIFT) / 64'(SERVO_ODD_DIV));
  localparam int unsigned SERVO_STAGES   = 3;
  localparam logic [15:0] SERVO_RESET    = 16'd1499;

  // Reply buffering: frames that may be in flight or waiting at the output
  localparam int unsigned FRAMES_IN_FLIGHT = 2;

  // Configuration register indexes
  localparam logic CFG_IDX_PERIOD_TOP  = 1'b0;
  localparam logic CFG_IDX_STATUS_WORD = 1'b1;
  localparam logic [15:0] PERIOD_TOP_RESET  = 16'd19999;
  localparam logic [15:0] STATUS_WORD_RESET = 16'd730;

  typedef logic [DUTY_COUNT-1:0][7:0] duty_vec_t;

  // Completed frame, as it leaves the deframer
  typedef struct packed {
    logic      ok;
    duty_vec_t duty;
  } frame_info_t;

  // One frame's reply, waiting at the output
  typedef struct packed {
    logic        ok;
    logic [15:0] reply;
    duty_vec_t   duty;
    logic [15:0] tilt;
    logic [15:0] pan;
  } reply_entry_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* src/crc_checked_pwm_command_deframer.sv */
// Top level of the CRC-checked PWM command deframer.
// Depends on crcpd_pkg, crcpd_deframer, crcpd_servo_scale, crcpd_reply_out.
`timescale 1ns / 1ps

// Receives a byte stream and gathers FRAME_LEN-byte command frames: byte 0 is
// a start byte (any value), bytes 1..4 are motor duties (fwd left, fwd right,
// back left, back right), bytes 5..6 tilt and 7..8 pan (high byte first), the
// rest CRC-16/MODBUS bytes. A 0xFF at any later position restarts the frame
// with itself as byte 0. When the CRC over the whole frame ends at zero, the
// duties and the servo compares floor(period_top*(1023+v)/20460), saturated to
// 16 bits, are latched. Every completed frame yields two reply transactions:
// status_word high byte then low byte (zero on a CRC failure), each carrying
// frame_ok and the latched duties and compares. Rate: one input byte per
// cycle. The closing byte of a frame is held off (in_tready low) only while
// the replies of two earlier frames are still in flight or unread; the two-
// entry reply buffer sets that limit. out_tvalid rises after the closing
// byte is taken, once the three-stage servo divide and then the reply buffer
// write have run; each reply is held on the output until out_tready takes it.
// period_top is sampled when a frame closes, so writes never rescale
// compares already latched. Reset values: period_top 19999, status_word 730,
// duties 0, compares 1499.

module crc_checked_pwm_command_deframer #(
  parameter int unsigned FRAME_LEN = crcpd_pkg::FRAME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  // reply stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // [7:0] reply_byte, [15:8] fwd_left_duty,
                                   // [23:16] fwd_right_duty, [31:24] back_left_duty,
                                   // [39:32] back_right_duty, [55:40] tilt_compare,
                                   // [71:56] pan_compare
  output logic        out_tuser,   // [0] frame_ok
  output logic        out_tlast,   // reply_last
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,   // 0 period_top, 1 status_word
  input  logic [15:0] cfg_data
);
  import crcpd_pkg::*;

  logic [15:0] period_top_r, period_top_nxt;
  logic [15:0] status_word_r, status_word_nxt;

  logic        fr_valid, frame_sent;
  frame_info_t fr_info;
  logic [15:0] tilt_val, pan_val, tilt_q, pan_q;

  // frame info rides alongside the servo divide pipeline
  logic        pipe_vld_r [SERVO_STAGES];
  frame_info_t pipe_info_r [SERVO_STAGES];

  // Configuration: always ready, one register per transaction
  assign cfg_ready = 1'b1;

  always_comb begin
    period_top_nxt  = period_top_r;
    status_word_nxt = status_word_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_PERIOD_TOP:  period_top_nxt  = cfg_data;
        CFG_IDX_STATUS_WORD: status_word_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_top_r  <= PERIOD_TOP_RESET;
      status_word_r <= STATUS_WORD_RESET;
    end else begin
      period_top_r  <= period_top_nxt;
      status_word_r <= status_word_nxt;
    end
  end

  crcpd_deframer #(
    .FRAME_LEN (FRAME_LEN)
  ) u_deframer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .frame_sent (frame_sent),
    .fr_valid   (fr_valid),
    .fr_info    (fr_info),
    .tilt_val   (tilt_val),
    .pan_val    (pan_val)
  );

  // Payload holds steady after a frame closes until the next frame's payload
  // bytes arrive, so the free-running divide pipes pick up the right operands.
  crcpd_servo_scale u_tilt_scale (
    .clk        (clk),
    .period_top (period_top_r),
    .raw_val    (tilt_val),
    .compare    (tilt_q)
  );

  crcpd_servo_scale u_pan_scale (
    .clk        (clk),
    .period_top (period_top_r),
    .raw_val    (pan_val),
    .compare    (pan_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SERVO_STAGES; s++) begin
        pipe_vld_r[s] <= 1'b0;
      end
    end else begin
      pipe_vld_r[0] <= fr_valid;
      for (int s = 1; s < SERVO_STAGES; s++) begin
        pipe_vld_r[s] <= pipe_vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_info_r[0] <= fr_info;
    for (int s = 1; s < SERVO_STAGES; s++) begin
      pipe_info_r[s] <= pipe_info_r[s-1];
    end
  end

  crcpd_reply_out u_reply_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .fr_valid    (pipe_vld_r[SERVO_STAGES-1]),
    .fr_info     (pipe_info_r[SERVO_STAGES-1]),
    .tilt_q      (tilt_q),
    .pan_q       (pan_q),
    .status_word (status_word_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .frame_sent  (frame_sent)
  );

endmodule

/* src/crcpd_deframer.sv */
// Byte deframer: frame index, running CRC, payload capture, motor duty latch.
// Depends on crcpd_pkg.
`timescale 1ns / 1ps

module crcpd_deframer #(
  parameter int unsigned FRAME_LEN = crcpd_pkg::FRAME_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,
  input  logic                     frame_sent,
  output logic                     fr_valid,
  output crcpd_pkg::frame_info_t   fr_info,
  output logic [15:0]              tilt_val,
  output logic [15:0]              pan_val
);
  import crcpd_pkg::*;

  localparam int unsigned IDX_W = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
  localparam int unsigned CNT_W = $clog2(FRAMES_IN_FLIGHT + 1);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       payload_r [PAYLOAD_BYTES];
  duty_vec_t        duty_r, duty_nxt;
  logic             fr_valid_r, fr_valid_nxt;
  logic             fr_ok_r, fr_ok_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic        accept, restart, at_last, closes;
  logic [15:0] crc_new;

  assign accept  = in_tvalid & in_tready;
  assign restart = (idx_r != '0) && (in_tdata == START_BYTE);
  assign at_last = (idx_r == LAST_IDX);
  assign closes  = accept & ~restart & at_last;
  assign crc_new = crc_feed(restart ? CRC_INIT : crc_r, in_tdata);

  // Closing byte waits only when both reply slots are taken
  assign in_tready = ~at_last || (cnt_r < CNT_W'(FRAMES_IN_FLIGHT));

  always_comb begin
    idx_nxt      = idx_r;
    crc_nxt      = crc_r;
    duty_nxt     = duty_r;
    fr_valid_nxt = closes;
    fr_ok_nxt    = fr_ok_r;
    if (accept) begin
      if (restart) begin
        idx_nxt = IDX_W'(1);
        crc_nxt = crc_new;
      end else if (at_last) begin
        idx_nxt   = '0;
        crc_nxt   = CRC_INIT;
        fr_ok_nxt = (crc_new == 16'h0000);
        if (crc_new == 16'h0000) begin
          for (int k = 0; k < DUTY_COUNT; k++) begin
            duty_nxt[k] = payload_r[k];
          end
        end
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
        crc_nxt = crc_new;
      end
    end
    cnt_nxt = cnt_r + CNT_W'(closes) - CNT_W'(frame_sent);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      crc_r      <= CRC_INIT;
      duty_r     <= '0;
      fr_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      idx_r      <= idx_nxt;
      crc_r      <= crc_nxt;
      duty_r     <= duty_nxt;
      fr_valid_r <= fr_valid_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_ok_r <= fr_ok_nxt;
  end

  // Payload bytes sit at frame indexes 1..8
  always_ff @(posedge clk) begin
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      if (accept && !restart && (idx_r == IDX_W'(k + 1))) begin
        payload_r[k] <= in_tdata;
      end
    end
  end

  assign fr_valid     = fr_valid_r;
  assign fr_info.ok   = fr_ok_r;
  assign fr_info.duty = duty_r;
  assign tilt_val     = {payload_r[4], payload_r[5]};
  assign pan_val      = {payload_r[6], payload_r[7]};

endmodule

/* src/crcpd_servo_scale.sv */
// Three-stage servo compare: multiply, reciprocal divide, correct and saturate.
// Depends on crcpd_pkg.
`timescale 1ns / 1ps

module crcpd_servo_scale (
  input  logic        clk,
  input  logic [15:0] period_top,
  input  logic [15:0] raw_val,
  output logic [15:0] compare
);
  import crcpd_pkg::*;

  localparam int unsigned PROD_W = 33;
  localparam int unsigned N_W    = PROD_W - SERVO_PRE_SHIFT;
  localparam int unsigned NM_W   = N_W + QUOT_W;

  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [N_W-1:0]    n_r;
  logic [QUOT_W-1:0] q0_r;
  logic [15:0]       cmp_r, cmp_nxt;

  logic [NM_W-1:0]   nm;
  logic [31:0]       qd, rem;
  logic [QUOT_W:0]   q1;

  assign prod_nxt = PROD_W'(period_top) * PROD_W'(SERVO_OFFSET + 17'(raw_val));
  assign nm       = NM_W'(prod_r[PROD_W-1:SERVO_PRE_SHIFT]) * NM_W'(SERVO_RECIP);

  // Estimate is exact or one low; one compare fixes it
  always_comb begin
    qd  = 32'(q0_r) * 32'(SERVO_ODD_DIV);
    rem = 32'(n_r) - qd;
    q1  = (QUOT_W + 1)'(q0_r) + (QUOT_W + 1)'(rem >= 32'(SERVO_ODD_DIV));
    cmp_nxt = (q1 > (QUOT_W + 1)'(16'hFFFF)) ? 16'hFFFF : q1[15:0];
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    n_r    <= prod_r[PROD_W-1:SERVO_PRE_SHIFT];
    q0_r   <= nm[RECIP_SHIFT +: QUOT_W];
    cmp_r  <= cmp_nxt;
  end

  assign compare = cmp_r;

endmodule

/* src/crcpd_reply_out.sv */
// Reply buffer: latches servo compares, queues frame replies, sends two bytes each.
// Depends on crcpd_pkg.
`timescale 1ns / 1ps

module crcpd_reply_out (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fr_valid,
  input  crcpd_pkg::frame_info_t fr_info,
  input  logic [15:0]            tilt_q,
  input  logic [15:0]            pan_q,
  input  logic [15:0]            status_word,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [71:0]            out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast,
  output logic                   frame_sent
);
  import crcpd_pkg::*;

  localparam int unsigned PTR_W = $clog2(FRAMES_IN_FLIGHT);
  localparam int unsigned CNT_W = $clog2(FRAMES_IN_FLIGHT + 1);

  reply_entry_t     fifo_r [FRAMES_IN_FLIGHT];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             phase_r, phase_nxt;
  logic [15:0]      tilt_r, tilt_nxt, pan_r, pan_nxt;

  reply_entry_t     push_entry, head;
  logic             out_acc;

  always_comb begin
    tilt_nxt = fr_info.ok ? tilt_q : tilt_r;
    pan_nxt  = fr_info.ok ? pan_q  : pan_r;
    push_entry.ok    = fr_info.ok;
    push_entry.reply = fr_info.ok ? status_word : 16'h0000;
    push_entry.duty  = fr_info.duty;
    push_entry.tilt  = tilt_nxt;
    push_entry.pan   = pan_nxt;
  end

  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_acc    = out_tvalid & out_tready;
  assign frame_sent = out_acc & phase_r;

  always_comb begin
    wr_ptr_nxt = fr_valid ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = frame_sent ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(fr_valid) - CNT_W'(frame_sent);
    phase_nxt  = out_acc ? ~phase_r : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      phase_r  <= 1'b0;
      tilt_r   <= SERVO_RESET;
      pan_r    <= SERVO_RESET;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
      if (fr_valid) begin
        tilt_r <= tilt_nxt;
        pan_r  <= pan_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fr_valid) begin
      fifo_r[wr_ptr_r] <= push_entry;
    end
  end

  assign out_tdata = {head.pan, head.tilt, head.duty,
                      phase_r ? head.reply[7:0] : head.reply[15:8]};
  assign out_tuser = head.ok;
  assign out_tlast = phase_r;

endmodule

/* test/tb_crc_checked_pwm_command_deframer.sv */
// Self-checking testbench for crc_checked_pwm_command_deframer.
// Streams framed and unframed bytes, predicts every reply transaction in-bench
// and checks them field by field; depends on crcpd_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_crc_checked_pwm_command_deframer;
  import crcpd_pkg::*;

  localparam int FRAME_BYTES  = 11;
  localparam int RANDOM_BYTES = 1100;
  localparam int SETTLE       = 16;        // well past the reply latency
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_REPORTS  = 40;

  // out_tdata layout, MSB first
  typedef struct packed {
    logic [15:0] pan;
    logic [15:0] tilt;
    logic [7:0]  back_right;
    logic [7:0]  back_left;
    logic [7:0]  fwd_right;
    logic [7:0]  fwd_left;
    logic [7:0]  reply;
  } reply_word_t;

  typedef struct {
    reply_word_t word;
    logic        ok;
    logic        last;
  } expected_reply_t;

  typedef logic [7:0][7:0]             payload_t;   // [0] fwd left .. [7] pan low
  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  crc_checked_pwm_command_deframer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: registers, frame gatherer and the latched outputs
  logic [15:0]      period_top_cfg  = 16'd19999;
  logic [15:0]      status_word_cfg = 16'd730;
  logic [3:0]       frame_pos = '0;
  logic [15:0]      crc_acc   = 16'hFFFF;
  payload_t         frame_body = '0;
  logic [3:0][7:0]  held_duty = '0;
  logic [15:0]      held_tilt = 16'd1499;
  logic [15:0]      held_pan  = 16'd1499;
  expected_reply_t  pending_replies[$];

  int  error_count;
  int  bytes_sent;
  int  good_replies;
  int  bad_replies;
  bit  tx_idle;                 // sender inserts random gaps
  bit  rx_idle;                 // receiver stalls at random
  bit  hold_request;            // receiver: start one long hold-off
  int  stall_left;
  int  cycle_count;

  // ---------------------------------------------------------------- prediction

  // One byte of CRC-16/MODBUS, LSB first, reflected polynomial
  function automatic logic [15:0] modbus_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ 16'hA001) : {1'b0, r[15:1]};
    return r;
  endfunction

  // floor(period_top * (1023 + v) / 20460), clipped to 16 bits
  function automatic logic [15:0] servo_compare(input logic [7:0] hi, input logic [7:0] lo);
    logic [63:0] q;
    q = (64'(period_top_cfg) * (64'd1023 + 64'({hi, lo}))) / 64'd20460;
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  // Runs one accepted byte through the frame gatherer; a closing byte queues
  // its two reply transactions.
  function automatic void deframe_byte(input logic [7:0] b);
    expected_reply_t e;
    logic            ok;
    logic [15:0]     reply;
    // 0xFF past the start position: resync, it becomes the new start byte
    if (frame_pos != 0 && b == 8'hFF) begin
      crc_acc   = modbus_step(16'hFFFF, b);
      frame_pos = 4'd1;
      return;
    end
    crc_acc = modbus_step(crc_acc, b);
    if (frame_pos >= 1 && frame_pos <= 8) frame_body[frame_pos - 1] = b;
    if (frame_pos < FRAME_BYTES - 1) begin
      frame_pos = frame_pos + 4'd1;
      return;
    end
    ok = (crc_acc == 16'h0000);
    if (ok) begin
      held_duty = frame_body[3:0];
      held_tilt = servo_compare(frame_body[4], frame_body[5]);
      held_pan  = servo_compare(frame_body[6], frame_body[7]);
    end
    reply     = ok ? status_word_cfg : 16'h0000;
    frame_pos = '0;
    crc_acc   = 16'hFFFF;
    for (int k = 0; k < 2; k++) begin
      e.word.reply      = (k == 0) ? reply[15:8] : reply[7:0];
      e.word.fwd_left   = held_duty[0];
      e.word.fwd_right  = held_duty[1];
      e.word.back_left  = held_duty[2];
      e.word.back_right = held_duty[3];
      e.word.tilt       = held_tilt;
      e.word.pan        = held_pan;
      e.ok              = ok;
      e.last            = (k == 1);
      pending_replies.push_back(e);
    end
  endfunction

  // ------------------------------------------------------------------ checking

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Receiver: checks each reply transaction, then picks next cycle's tready.
  // Stall lengths are counted here, including the long hold-off on request.
  always @(posedge clk) begin
    expected_reply_t e;
    reply_word_t     got;
    int              r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_replies.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected reply transaction, expected none, actual %0h",
                     $time, out_tdata);
        end else begin
          e = pending_replies.pop_front();
          check_field("reply_byte",      16'(e.word.reply),      16'(got.reply));
          check_field("reply_last",      16'(e.last),            16'(out_tlast));
          check_field("frame_ok",        16'(e.ok),              16'(out_tuser));
          check_field("fwd_left_duty",   16'(e.word.fwd_left),   16'(got.fwd_left));
          check_field("fwd_right_duty",  16'(e.word.fwd_right),  16'(got.fwd_right));
          check_field("back_left_duty",  16'(e.word.back_left),  16'(got.back_left));
          check_field("back_right_duty", 16'(e.word.back_right), 16'(got.back_right));
          check_field("tilt_compare",    e.word.tilt,            got.tilt);
          check_field("pan_compare",     e.word.pan,             got.pan);
          if (e.ok) good_replies++;
          else bad_replies++;
        end
      end

      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (!rx_idle) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          if (r < 92) stall_left = $urandom_range(0, 3);
          else stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------ stimulus

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One input transaction. tvalid stays high into the next call when there is
  // no gap, so it is never dropped and raised in the same step.
  task automatic send_rx(input logic [7:0] b);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame_bytes(input frame_t f, input int count);
    for (int k = 0; k < count; k++) send_rx(f[k]);
  endtask

  // Sender pause: nothing offered until every expected reply is back
  task automatic wait_replies_drained();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes both registers back to back while the block is idle
  task automatic set_registers(input logic [15:0] period, input logic [15:0] status);
    wait_replies_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_PERIOD_TOP;
    cfg_data  <= period;
    do @(posedge clk); while (!cfg_ready);
    period_top_cfg = period;
    cfg_index <= CFG_IDX_STATUS_WORD;
    cfg_data  <= status;
    do @(posedge clk); while (!cfg_ready);
    status_word_cfg = status;
    cfg_valid <= 1'b0;
  endtask

  // Frame with a valid CRC, no 0xFF past the start byte. A CRC byte of 0xFF
  // would restart the frame, so nudge the start byte (or pan low) until clean.
  function automatic frame_t build_frame(input logic [7:0] start, input payload_t body,
                                         input bit start_fixed);
    frame_t      f;
    logic [15:0] c;
    for (int k = 0; k < 8; k++) if (body[k] == 8'hFF) body[k] = 8'hFE;
    repeat (512) begin
      c = modbus_step(16'hFFFF, start);
      for (int k = 0; k < 8; k++) c = modbus_step(c, body[k]);
      if (c[7:0] != 8'hFF && c[15:8] != 8'hFF) break;
      if (start_fixed) body[7] = (body[7] == 8'hFE) ? 8'h00 : body[7] + 8'h01;
      else start = start + 8'h01;
    end
    f[0]   = start;
    f[8:1] = body;
    f[9]   = c[7:0];
    f[10]  = c[15:8];
    return f;
  endfunction

  function automatic payload_t random_body();
    payload_t p;
    int       r;
    for (int k = 0; k < 8; k++) begin
      r = $urandom_range(0, 9);
      if (r == 0) p[k] = 8'h00;
      else if (r == 1) p[k] = 8'hFE;
      else p[k] = 8'($urandom_range(0, 254));
    end
    return p;
  endfunction

  // ------------------------------------------------------------- test tasks

  // Reset values show on a bad frame, then a plain good frame latches
  task automatic test_reset_values();
    frame_t f;
    f = '0;
    send_frame_bytes(f, FRAME_BYTES);
    f = build_frame(8'h00, {8'h00, 8'h00, 8'hE8, 8'h03, 8'h40, 8'h30, 8'h20, 8'h10}, 1'b0);
    send_frame_bytes(f, FRAME_BYTES);
    wait_replies_drained();
  endtask

  // Register extremes, compare saturation and held values after a CRC failure
  task automatic test_register_extremes();
    frame_t f;
    set_registers(16'hFFFF, 16'hFFFF);
    f = build_frame(8'hA5, {8{8'hFE}}, 1'b0);             // compares saturate
    send_frame_bytes(f, FRAME_BYTES);
    set_registers(16'h0000, 16'h0000);
    f = build_frame(8'h5A, {8'h7F, 8'h80, 8'h01, 8'h80, 8'h01, 8'h7F, 8'h80, 8'h01}, 1'b0);
    send_frame_bytes(f, FRAME_BYTES);                     // good frame, zero reply
    // new period must not touch compares that are already latched
    set_registers(16'd19999, 16'h5AA5);
    f = build_frame(8'h11, {8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88, 8'h99}, 1'b0);
    f[9] = f[9] ^ 8'h01;
    if (f[9] == 8'hFF) f[9] = 8'h00;
    send_frame_bytes(f, FRAME_BYTES);
    set_registers(16'd20460, 16'd730);
    f = build_frame(8'hFF, '0, 1'b1);
    send_frame_bytes(f, FRAME_BYTES);
    wait_replies_drained();
  endtask

  // 0xFF mid-payload and at both CRC positions restarts the frame
  task automatic test_restarts();
    frame_t f;
    frame_t g;
    f = build_frame(8'h3C, {8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08}, 1'b0);
    g = build_frame(8'hFF, {8'hC8, 8'h64, 8'h32, 8'h19, 8'h12, 8'h34, 8'h56, 8'h78}, 1'b1);
    send_frame_bytes(f, 3);
    send_frame_bytes(g, FRAME_BYTES);
    send_frame_bytes(f, 9);                               // 0xFF lands on CRC low
    send_frame_bytes(g, FRAME_BYTES);
    send_frame_bytes(f, 10);                              // 0xFF lands on CRC high
    send_frame_bytes(g, FRAME_BYTES);
    wait_replies_drained();
  endtask

  // Long receiver hold-off while frames keep coming, then a full drain
  task automatic test_backpressure();
    frame_t f;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_request = 1'b1;
    repeat (6) begin
      f = build_frame(8'($urandom_range(0, 255)), random_body(), 1'b0);
      send_frame_bytes(f, FRAME_BYTES);
    end
    wait_replies_drained();
  endtask

  // Mostly well-formed frames with random content; the rest corrupted,
  // truncated, resynced or plain noise. Registers change between phases.
  task automatic test_random_traffic();
    frame_t f;
    frame_t g;
    int     first_byte;
    int     kind;
    int     pos;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < RANDOM_BYTES) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0:       set_registers(16'hFFFF, 16'(~status_word_cfg));
          1:       set_registers(16'h0000, 16'($urandom_range(0, 65535)));
          default: set_registers(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        endcase
      end
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      repeat (8) begin
        kind = $urandom_range(0, 99);
        f = build_frame(8'($urandom_range(0, 255)), random_body(), 1'b0);
        if (kind < 70) begin
          send_frame_bytes(f, FRAME_BYTES);
        end else if (kind < 80) begin
          pos = $urandom_range(1, FRAME_BYTES - 1);
          f[pos] = f[pos] ^ 8'(1 << $urandom_range(0, 7));
          send_frame_bytes(f, FRAME_BYTES);
        end else if (kind < 88) begin
          send_frame_bytes(f, $urandom_range(1, FRAME_BYTES - 1));
        end else if (kind < 95) begin
          repeat ($urandom_range(1, 15)) send_rx(8'($urandom_range(0, 255)));
        end else begin
          g = build_frame(8'hFF, random_body(), 1'b1);
          send_frame_bytes(f, $urandom_range(1, FRAME_BYTES - 1));
          send_frame_bytes(g, FRAME_BYTES);
        end
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_IDX_PERIOD_TOP;
    cfg_data     = '0;
    out_tready   = 1'b0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_register_extremes();
    test_restarts();
    test_backpressure();
    test_random_traffic();
    wait_replies_drained();

    $display("Sent %0d bytes; checked %0d reply transactions (%0d good-frame, %0d bad-frame).",
             bytes_sent, good_replies + bad_replies, good_replies, bad_replies);
    $display("Covered register extremes, resync on 0xFF, CRC failures and output backpressure.");
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* crc_checked_pwm_command_deframer.f */
src/crcpd_pkg.sv
src/crcpd_deframer.sv
src/crcpd_servo_scale.sv
src/crcpd_reply_out.sv
src/crc_checked_pwm_command_deframer.sv
test/tb_crc_checked_pwm_command_deframer.sv
